@@ hw/rtl/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Payload structs, phase encoding, register indexes and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Register indexes on the configuration channel
  localparam logic [1:0] CFG_ECHO_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_TRIG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_GAP          = 2'd2;

  // Register reset values
  localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd3000;
  localparam logic [7:0]  TRIG_WIDTH_RST   = 8'd20;
  localparam logic [9:0]  GAP_RST          = 10'd50;

  // Round-trip echo time per cm, in us
  localparam int unsigned US_PER_CM = 58;

  localparam int unsigned SUM_W   = 20;
  localparam int unsigned NUM_W   = SUM_W + 4;  // width sum scaled by 16
  localparam int unsigned DIST_W  = 15;
  localparam int unsigned RECIP_SHIFT = NUM_W + 1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_pl_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance;
    logic              timed_out;
  } out_pl_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_pl_t;

  // Result of one tick step, before the distance division
  typedef struct packed {
    logic             trigger_level;
    logic             busy_res;
    logic             done_res;
    logic             timed_out;
    logic [NUM_W-1:0] num;
  } step_t;

endpackage

`default_nettype wire

@@ hw/rtl/uer_chan_if.sv @@
// ----------------------------------------------------------------------------
// uer_chan_if: valid/ready channel
// Carries one payload struct per request between a source and a sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface uer_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo-pulse ultrasonic distance ranger
// Tick-driven trigger/echo sequencer with averaged distance output.
// ----------------------------------------------------------------------------
// Each request is one microsecond tick carrying the sampled echo pin level and
// a start flag; each request yields exactly one result holding the trigger pin
// level and busy flag for that tick. A start seen while idle runs SAMPLES
// rounds: trigger pulse, wait for echo rise, count echo high time (capped at
// echo_timeout_us, also used as the rise wait limit), then gap_us idle ticks.
// On the tick the last round closes, done_res pulses with the mean distance
// floor(sum*16 / (58*SAMPLES)) in 1/16 cm, saturated at 32767, plus a flag if
// any round timed out. Throughput is one request per cycle while the output
// is not back-pressured; a result is offered once its request has passed the
// input, sequencer step and reciprocal multiply registers into the result
// register. Output back-pressure fills the pipeline before in_if.ready drops.
// Registers on cfg_if (index 0/1/2): echo timeout, trigger width, gap.
// Write them only while idle; cfg_if is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int unsigned SAMPLES = 5  // rounds per measurement, 1..8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uer_chan_if.sink   in_if,
  uer_chan_if.source out_if,
  uer_chan_if.sink   cfg_if
);

  // Stage 0: input register
  logic             s0_v_q;
  uer_pkg::in_pl_t  s0_q;
  logic             s0_ready;

  // Stage 1: sequencer step result
  logic             s1_v_q;
  uer_pkg::step_t   s1_q;
  logic             s1_ready;

  uer_pkg::step_t   step_res;
  logic             step_en;
  logic             div_ready;
  uer_pkg::in_pl_t  in_pl;
  uer_pkg::cfg_pl_t cfg_pl;
  uer_pkg::out_pl_t out_pl;

  assign in_pl  = in_if.payload;
  assign cfg_pl = cfg_if.payload;

  assign cfg_if.ready = 1'b1;

  assign s1_ready    = !s1_v_q || div_ready;
  assign s0_ready    = !s0_v_q || s1_ready;
  assign in_if.ready = s0_ready;

  // State advances exactly when a tick moves from stage 0 to stage 1
  assign step_en = s0_v_q && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_v_q <= in_if.valid;
      end
      if (s1_ready) begin
        s1_v_q <= s0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_if.valid) begin
      s0_q <= in_pl;
    end
    if (step_en) begin
      s1_q <= step_res;
    end
  end

  uer_core #(
    .SAMPLES (SAMPLES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_if.valid),
    .cfg_i     (cfg_pl),
    .step_en_i (step_en),
    .req_i     (s0_q),
    .res_o     (step_res)
  );

  uer_div #(
    .SAMPLES (SAMPLES)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q),
    .in_ready_o  (div_ready),
    .in_res_i    (s1_q),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_res_o   (out_pl)
  );

  assign out_if.payload = out_pl;

endmodule

`default_nettype wire

@@ hw/rtl/uer_core.sv @@
// ----------------------------------------------------------------------------
// uer_core: ranging sequencer
// Config registers, phase state and width accumulation; one step per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_core #(
  parameter int unsigned SAMPLES = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire uer_pkg::cfg_pl_t cfg_i,
  input  wire logic            step_en_i,
  input  wire uer_pkg::in_pl_t req_i,
  output      uer_pkg::step_t  res_o
);

  logic [15:0] timeout_q;
  logic [7:0]  trig_w_q;
  logic [9:0]  gap_q;

  uer_pkg::phase_e          phase_q, phase_d;
  logic [15:0]              ticks_q, ticks_d;
  logic [2:0]               round_q, round_d;
  logic [uer_pkg::SUM_W-1:0] sum_q, sum_d;
  logic                     seen_q, seen_d;

  logic [15:0] lim;
  logic [7:0]  tw;
  logic [15:0] ticks_inc;
  logic        end_rnd;
  logic [15:0] end_w;
  logic        end_to;
  logic        close;
  logic        done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= uer_pkg::ECHO_TIMEOUT_RST;
      trig_w_q  <= uer_pkg::TRIG_WIDTH_RST;
      gap_q     <= uer_pkg::GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        uer_pkg::CFG_ECHO_TIMEOUT: timeout_q <= cfg_i.data;
        uer_pkg::CFG_TRIG_WIDTH:   trig_w_q  <= cfg_i.data[7:0];
        uer_pkg::CFG_GAP:          gap_q     <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lim       = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
    tw        = (trig_w_q == 8'd0) ? 8'd1 : trig_w_q;
    ticks_inc = ticks_q + 16'd1;
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    round_d   = round_q;
    sum_d     = sum_q;
    seen_d    = seen_q;
    end_rnd   = 1'b0;
    end_w     = lim;
    end_to    = 1'b0;
    close     = 1'b0;
    done      = 1'b0;

    unique case (phase_q)
      uer_pkg::PH_TRIG: begin
        if (ticks_inc >= {8'd0, tw}) begin
          phase_d = uer_pkg::PH_WAIT;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (req_i.echo_level) begin
          if (lim <= 16'd1) begin
            end_rnd = 1'b1;
            end_to  = 1'b1;
          end else begin
            phase_d = uer_pkg::PH_MEAS;
            ticks_d = 16'd1;
          end
        end else begin
          ticks_d = ticks_inc;
          if (ticks_inc >= lim) begin
            end_rnd = 1'b1;
            end_to  = 1'b1;
          end
        end
      end
      uer_pkg::PH_MEAS: begin
        if (req_i.echo_level) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= lim) begin
            end_rnd = 1'b1;
            end_to  = 1'b1;
          end
        end else begin
          end_rnd = 1'b1;
          end_w   = ticks_q;
        end
      end
      uer_pkg::PH_GAP: begin
        ticks_d = ticks_inc;
        if (ticks_inc >= {6'd0, gap_q}) begin
          close = 1'b1;
        end
      end
      uer_pkg::PH_IDLE: begin
        if (req_i.start_req) begin
          phase_d = uer_pkg::PH_TRIG;
          ticks_d = '0;
          round_d = '0;
          sum_d   = '0;
          seen_d  = 1'b0;
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
      end
    endcase

    if (end_rnd) begin
      sum_d   = sum_q + {{(uer_pkg::SUM_W-16){1'b0}}, end_w};
      seen_d  = seen_q | end_to;
      ticks_d = '0;
      if (gap_q == 10'd0) begin
        close = 1'b1;
      end else begin
        phase_d = uer_pkg::PH_GAP;
      end
    end

    if (close) begin
      ticks_d = '0;
      if (({1'b0, round_q} + 4'd1) >= 4'(SAMPLES)) begin
        done    = 1'b1;
        phase_d = uer_pkg::PH_IDLE;
      end else begin
        round_d = round_q + 3'd1;
        phase_d = uer_pkg::PH_TRIG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PH_IDLE;
      ticks_q <= '0;
      round_q <= '0;
      sum_q   <= '0;
      seen_q  <= 1'b0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      round_q <= round_d;
      sum_q   <= sum_d;
      seen_q  <= seen_d;
    end
  end

  // Trigger and busy follow the phase held at the start of the tick; done, timeout and sum come from this step
  always_comb begin
    res_o.trigger_level = (phase_q == uer_pkg::PH_TRIG);
    res_o.busy_res      = (phase_q != uer_pkg::PH_IDLE);
    res_o.done_res      = done;
    res_o.timed_out     = seen_d;
    res_o.num           = {sum_d, 4'd0};
  end

endmodule

`default_nettype wire

@@ hw/rtl/uer_div.sv @@
// ----------------------------------------------------------------------------
// uer_div: distance divider pipeline
// Divides the scaled width sum by 58*SAMPLES via reciprocal multiply and one
// correction step; two stages, the second being the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_div #(
  parameter int unsigned SAMPLES = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire uer_pkg::step_t   in_res_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      uer_pkg::out_pl_t out_res_o
);

  localparam int unsigned DIV   = uer_pkg::US_PER_CM * SAMPLES;
  localparam int unsigned RECIP = (2 ** uer_pkg::RECIP_SHIFT) / DIV;
  localparam int unsigned NUM_W = uer_pkg::NUM_W;
  localparam int unsigned PROD_W = NUM_W + 20;
  localparam int unsigned QE_W  = PROD_W - uer_pkg::RECIP_SHIFT;

  localparam logic [8:0]  DIV_C   = 9'(DIV);
  localparam logic [19:0] RECIP_C = 20'(RECIP);

  logic                  s2_v_q;
  uer_pkg::step_t        s2_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  s3_v_q;
  uer_pkg::out_pl_t      s3_q;
  logic                  s2_ready;
  logic                  s3_ready;

  logic [QE_W-1:0]       q_est;
  logic [QE_W+8:0]       q_mul;
  logic [NUM_W-1:0]      rem;
  logic [QE_W:0]         quot;
  uer_pkg::out_pl_t      s3_d;

  assign s3_ready   = !s3_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign in_ready_o = s2_ready;

  // q_est is q or q-1; one compare settles it
  always_comb begin
    q_est = prod_q[PROD_W-1:uer_pkg::RECIP_SHIFT];
    q_mul = (QE_W+9)'(q_est) * (QE_W+9)'(DIV_C);
    rem   = s2_q.num - q_mul[NUM_W-1:0];
    quot  = {1'b0, q_est} + ((rem >= NUM_W'(DIV_C)) ? (QE_W+1)'(1) : '0);

    s3_d.trigger_level = s2_q.trigger_level;
    s3_d.busy_res      = s2_q.busy_res;
    s3_d.done_res      = s2_q.done_res;
    s3_d.timed_out     = s2_q.done_res & s2_q.timed_out;
    if (!s2_q.done_res) begin
      s3_d.distance = '0;
    end else if (quot > (QE_W+1)'(uer_pkg::DIST_MAX)) begin
      s3_d.distance = uer_pkg::DIST_MAX;
    end else begin
      s3_d.distance = quot[uer_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_q <= in_valid_i;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && in_valid_i) begin
      s2_q   <= in_res_i;
      prod_q <= PROD_W'(in_res_i.num) * PROD_W'(RECIP_C);
    end
    if (s3_ready && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_res_o   = s3_q;

endmodule

`default_nettype wire
